FILE: src/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// shared types and codes of the moment-sum covariance / correlation unit
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    typedef enum logic [1:0] {
        MODE_SCATTER = 2'd0,
        MODE_COV     = 2'd1,
        MODE_CORR    = 2'd2,
        MODE_DET     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONPOS = 2'd1,
        ST_SAT    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_BIASED  = 2'd1,
        REG_MIN_VAR = 2'd2
    } t_reg_idx;

    // per-lane control taken from the configuration registers
    typedef struct packed {
        logic biased;
        logic scatter;
    } t_cov_ctl;

endpackage

`default_nettype wire

FILE: src/msc_mul.sv
// ----------------------------------------------------------------------------
// msc_mul
// two-stage unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`default_nettype none

module msc_mul #(
    parameter int MW = 48,
    parameter int SW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [MW-1:0]     i_a,
    input  wire logic [MW-1:0]     i_b,
    input  wire logic [SW-1:0]     i_sb,
    output logic                   o_valid,
    output logic [2*MW-1:0]        o_p,
    output logic [SW-1:0]          o_sb
);

    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;
    localparam int PW = 2 * MW;

    logic [2*H-1:0]  r_ll;
    logic [H+HW-1:0] r_lh;
    logic [H+HW-1:0] r_hl;
    logic [2*HW-1:0] r_hh;
    logic [SW-1:0]   r_sb1;
    logic [SW-1:0]   r_sb2;
    logic [PW-1:0]   r_p;
    logic            r_v1;
    logic            r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= i_a[H-1:0] * i_b[H-1:0];
            r_lh  <= i_a[H-1:0] * i_b[MW-1:H];
            r_hl  <= i_a[MW-1:H] * i_b[H-1:0];
            r_hh  <= i_a[MW-1:H] * i_b[MW-1:H];
            r_sb1 <= i_sb;
            r_p   <= PW'(r_ll) + (PW'(r_lh) << H) + (PW'(r_hl) << H)
                     + (PW'(r_hh) << (2 * H));
            r_sb2 <= r_sb1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_sb    = r_sb2;

endmodule

`default_nettype wire

FILE: src/msc_div.sv
// ----------------------------------------------------------------------------
// msc_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module msc_div #(
    parameter int NW = 96,
    parameter int DW = 48,
    parameter int QW = 48,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_n,
    input  wire logic [DW-1:0] i_d,
    input  wire logic [SW-1:0] i_sb,
    output logic               o_valid,
    output logic [QW-1:0]      o_q,
    output logic               o_ov,
    output logic [SW-1:0]      o_sb
);

    localparam int TW = NW - QW;
    localparam int CW = (TW > DW) ? TW : DW;

    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_nq  [0:QW];
    logic [DW-1:0] r_d   [0:QW];
    logic [SW-1:0] r_sb  [0:QW];
    logic [QW:0]   r_ov;
    logic [QW:0]   r_v;

    logic [DW:0]   n_t   [0:QW-1];
    logic [QW-1:0] n_ge;
    logic [DW-1:0] n_rem [0:QW-1];
    logic [QW-1:0] n_nq  [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            n_t[k]   = {r_rem[k], r_nq[k][QW-1]};
            n_ge[k]  = n_t[k] >= {1'b0, r_d[k]};
            n_rem[k] = n_ge[k] ? DW'(n_t[k] - {1'b0, r_d[k]}) : DW'(n_t[k]);
            n_nq[k]  = {r_nq[k][QW-2:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient bits above QW mean overflow
            r_rem[0] <= DW'(i_n[NW-1:QW]);
            r_nq[0]  <= i_n[QW-1:0];
            r_d[0]   <= i_d;
            r_sb[0]  <= i_sb;
            r_ov[0]  <= CW'(i_n[NW-1:QW]) >= CW'(i_d);
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_nq[k+1]  <= n_nq[k];
                r_d[k+1]   <= r_d[k];
                r_sb[k+1]  <= r_sb[k];
                r_ov[k+1]  <= r_ov[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_q     = r_nq[QW];
    assign o_ov    = r_ov[QW];
    assign o_sb    = r_sb[QW];

endmodule

`default_nettype wire

FILE: src/msc_sqrt.sv
// ----------------------------------------------------------------------------
// msc_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module msc_sqrt #(
    parameter int RW = 47,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RW-1:0] i_p,
    input  wire logic [SW-1:0]   i_sb,
    output logic                 o_valid,
    output logic [RW-1:0]        o_r,
    output logic [SW-1:0]        o_sb
);

    logic [RW+1:0]   r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    logic [2*RW-1:0] r_bits [0:RW];
    logic [SW-1:0]   r_sb   [0:RW];
    logic [RW:0]     r_v;

    logic [RW+1:0]   n_s     [0:RW-1];
    logic [RW+1:0]   n_trial [0:RW-1];
    logic [RW-1:0]   n_ge;
    logic [RW+1:0]   n_rem   [0:RW-1];
    logic [RW-1:0]   n_root  [0:RW-1];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            n_s[k]     = {r_rem[k][RW-1:0], r_bits[k][2*RW-1:2*RW-2]};
            n_trial[k] = {r_root[k], 2'b01};
            n_ge[k]    = n_s[k] >= n_trial[k];
            n_rem[k]   = n_ge[k] ? n_s[k] - n_trial[k] : n_s[k];
            n_root[k]  = {r_root[k][RW-2:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_bits[0] <= i_p;
            r_sb[0]   <= i_sb;
            for (int k = 0; k < RW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
                r_bits[k+1] <= r_bits[k] << 2;
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_r     = r_root[RW];
    assign o_sb    = r_sb[RW];

endmodule

`default_nettype wire

FILE: src/msc_cov.sv
// ----------------------------------------------------------------------------
// msc_cov
// covariance lane: product of sums, mean correction, scaling by divisor
// ----------------------------------------------------------------------------
`default_nettype none

module msc_cov
    import msc_pkg::*;
#(
    parameter int W = 48,
    parameter int F = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire t_cov_ctl     i_ctl,
    input  wire logic [W-2:0] i_min_var,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_size,
    output logic              o_valid,
    output logic [W-1:0]      o_r,
    output logic              o_sat
);

    localparam logic [W-1:0] ONE  = W'(1) << F;
    localparam logic [W-1:0] HALF = W'(1) << (W - 1);
    localparam int SW1 = 3 + 3 * W;
    localparam int SW2 = 3 + 2 * W;
    localparam int NW2 = 2 * W + F;

    // input stage
    logic          r0_v;
    logic [W-1:0]  r0_ma;
    logic [W-1:0]  r0_mb;
    logic [SW1-1:0] r0_sb;
    logic          n0_nx;
    logic          n0_na;
    logic          n0_nb;
    logic [W-1:0]  n0_mx;
    logic          n0_bypass;
    logic [W-1:0]  n0_den;

    assign n0_nx = i_x[W-1];
    assign n0_na = i_a[W-1];
    assign n0_nb = i_b[W-1];
    assign n0_mx = n0_nx ? W'(-i_x) : i_x;
    assign n0_den = (i_ctl.biased || i_ctl.scatter) ? i_size : i_size - ONE;

    always_comb begin
        if (i_ctl.scatter || i_ctl.biased) begin
            n0_bypass = (i_size == '0);
        end else begin
            n0_bypass = (i_size <= ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ma <= n0_na ? W'(-i_a) : i_a;
            r0_mb <= n0_nb ? W'(-i_b) : i_b;
            r0_sb <= {n0_bypass, n0_nx, n0_na ^ n0_nb, n0_mx, i_size, n0_den};
        end
    end

    // product of the two component sums
    logic           m_v;
    logic [2*W-1:0] m_p;
    logic [SW1-1:0] m_sb;

    msc_mul #(.MW(W), .SW(SW1)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r0_v),
        .i_a     (r0_ma),
        .i_b     (r0_mb),
        .i_sb    (r0_sb),
        .o_valid (m_v),
        .o_p     (m_p),
        .o_sb    (m_sb)
    );

    // mean correction term a*b/size
    logic           q_v;
    logic [2*W-2:0] q_q;
    logic [SW2-1:0] q_sb;

    msc_div #(.NW(2 * W), .DW(W), .QW(2 * W - 1), .SW(SW2)) u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (m_v),
        .i_n     (m_p),
        .i_d     (m_sb[2*W-1:W]),
        .i_sb    ({m_sb[SW1-1:3*W], m_sb[3*W-1:2*W], m_sb[W-1:0]}),
        .o_valid (q_v),
        .o_q     (q_q),
        .o_ov    (),
        .o_sb    (q_sb)
    );

    // exact signed difference x - q in sign-magnitude, or x alone in scatter mode
    logic           q_bypass;
    logic           q_nx;
    logic           q_tneg;
    logic [W-1:0]   q_mx;
    logic [W-1:0]   q_den;
    logic [2*W-1:0] n_qx;
    logic [2*W-1:0] n_mxx;
    logic [2*W-1:0] n_d;
    logic           n_dneg;

    assign q_bypass = q_sb[SW2-1];
    assign q_nx     = q_sb[SW2-2];
    assign q_tneg   = q_sb[SW2-3];
    assign q_mx     = q_sb[2*W-1:W];
    assign q_den    = q_sb[W-1:0];
    assign n_qx     = (2 * W)'(q_q);
    assign n_mxx    = (2 * W)'(q_mx);

    always_comb begin
        if (i_ctl.scatter) begin
            n_d    = n_mxx;
            n_dneg = q_nx;
        end else if (q_nx == !q_tneg) begin
            n_d    = n_mxx + n_qx;
            n_dneg = q_nx;
        end else if (n_mxx < n_qx) begin
            n_d    = n_qx - n_mxx;
            n_dneg = !q_tneg;
        end else begin
            n_d    = n_mxx - n_qx;
            n_dneg = q_nx;
        end
    end

    logic           rd_v;
    logic [2*W-1:0] rd_d;
    logic           rd_dneg;
    logic [W-1:0]   rd_den;
    logic           rd_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else if (i_en) begin
            rd_v <= q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rd_d      <= n_d;
            rd_dneg   <= n_dneg;
            rd_den    <= q_den;
            rd_bypass <= q_bypass;
        end
    end

    // scale by 2^F and divide by the divisor
    logic         c_v;
    logic [W-1:0] c_q;
    logic         c_ov;
    logic [1:0]   c_sb;

    msc_div #(.NW(NW2), .DW(W), .QW(W), .SW(2)) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (rd_v),
        .i_n     (NW2'(rd_d) << F),
        .i_d     (rd_den),
        .i_sb    ({rd_bypass, rd_dneg}),
        .o_valid (c_v),
        .o_q     (c_q),
        .o_ov    (c_ov),
        .o_sb    (c_sb)
    );

    // saturation and variance floor
    logic [W-1:0] n_limit;
    logic         n_sat;
    logic [W-1:0] n_m;
    logic [W-1:0] n_r;
    logic         n_floor;

    assign n_limit = c_sb[0] ? HALF : HALF - W'(1);
    assign n_sat   = c_ov || (c_q > n_limit);
    assign n_m     = n_sat ? n_limit : c_q;
    assign n_r     = c_sb[0] ? W'(-n_m) : n_m;
    assign n_floor = !i_ctl.scatter && (n_m < W'(i_min_var));

    logic         r_v;
    logic [W-1:0] r_r;
    logic         r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (c_sb[1]) begin
                r_r   <= i_ctl.scatter ? '0 : W'(i_min_var);
                r_sat <= 1'b0;
            end else begin
                r_r   <= n_floor ? W'(i_min_var) : n_r;
                r_sat <= n_sat;
            end
        end
    end

    assign o_valid = r_v;
    assign o_r     = r_r;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

FILE: src/moment_sum_covariance_correlation_unit.sv
// every mode passes through the whole pipeline from input request to result
// throughput: one request per cycle; the whole pipeline advances together and
//   holds while a finished result is stalled at the output register
// the pipeline depth is set by the bit-per-stage dividers and square root
// reset: synchronous, active low; clears valid bits and loads mode 1, unbiased,
//   floor 0
// ----------------------------------------------------------------------------
// moment_sum_covariance_correlation_unit
// scatter, covariance, correlation and determination from moment sums
// ----------------------------------------------------------------------------
`default_nettype none

module moment_sum_covariance_correlation_unit
    import msc_pkg::*;
#(
    parameter int WORD_BITS = 48,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [WORD_BITS-2:0] i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [WORD_BITS-1:0] i_cross_sum,
    input  wire logic [WORD_BITS-1:0] i_sum_first,
    input  wire logic [WORD_BITS-1:0] i_sum_second,
    input  wire logic [WORD_BITS-1:0] i_square_sum_first,
    input  wire logic [WORD_BITS-1:0] i_square_sum_second,
    input  wire logic [WORD_BITS-1:0] i_sample_size,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [WORD_BITS-1:0]      o_estimate,
    output logic [1:0]                o_status
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (W - 1);
    localparam int SW2 = 2 * W + 3;
    localparam int SW3 = 2 * W + 2;

    // configuration registers
    t_mode        r_mode;
    logic         r_biased;
    logic [W-2:0] r_min_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_COV;
            r_biased  <= 1'b0;
            r_min_var <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                REG_BIASED:  r_biased  <= i_cfg_data[0];
                REG_MIN_VAR: r_min_var <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    logic ratio_mode;

    assign en         = !(r_out_valid && i_stall);
    assign o_stall    = !en;
    assign ratio_mode = (r_mode == MODE_CORR) || (r_mode == MODE_DET);

    t_cov_ctl ctl_c;
    t_cov_ctl ctl_v;

    assign ctl_c.biased  = r_biased;
    assign ctl_c.scatter = (r_mode == MODE_SCATTER);
    assign ctl_v.biased  = r_biased;
    assign ctl_v.scatter = 1'b0;

    // three covariance lanes: cross term and the two variances
    logic         c_v;
    logic [W-1:0] c_r;
    logic         c_sat;
    logic [W-1:0] vn_r;
    logic         vn_sat;
    logic [W-1:0] vm_r;
    logic         vm_sat;

    msc_cov #(.W(W), .F(F)) u_cov_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_ctl     (ctl_c),
        .i_min_var (r_min_var),
        .i_x       (i_cross_sum),
        .i_a       (i_sum_first),
        .i_b       (i_sum_second),
        .i_size    (i_sample_size),
        .o_valid   (c_v),
        .o_r       (c_r),
        .o_sat     (c_sat)
    );

    msc_cov #(.W(W), .F(F)) u_cov_first (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_ctl     (ctl_v),
        .i_min_var (r_min_var),
        .i_x       (i_square_sum_first),
        .i_a       (i_sum_first),
        .i_b       (i_sum_first),
        .i_size    (i_sample_size),
        .o_valid   (),
        .o_r       (vn_r),
        .o_sat     (vn_sat)
    );

    msc_cov #(.W(W), .F(F)) u_cov_second (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_ctl     (ctl_v),
        .i_min_var (r_min_var),
        .i_x       (i_square_sum_second),
        .i_a       (i_sum_second),
        .i_b       (i_sum_second),
        .i_size    (i_sample_size),
        .o_valid   (),
        .o_r       (vm_r),
        .o_sat     (vm_sat)
    );

    // check variances, split the cross covariance into sign and magnitude
    logic         r1_v;
    logic [W-1:0] r1_cr;
    logic         r1_cneg;
    logic [W-1:0] r1_cmag;
    logic [W-2:0] r1_vn;
    logic [W-2:0] r1_vm;
    logic         r1_bad;
    logic         r1_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cr   <= c_r;
            r1_cneg <= c_r[W-1];
            r1_cmag <= c_r[W-1] ? W'(-c_r) : c_r;
            r1_vn   <= vn_r[W-2:0];
            r1_vm   <= vm_r[W-2:0];
            r1_bad  <= (vn_r == '0) || vn_r[W-1] || (vm_r == '0) || vm_r[W-1];
            // variance saturation only counts when the variances are used
            r1_flag <= c_sat || (ratio_mode && (vn_sat || vm_sat));
        end
    end

    logic           p2_v;
    logic [2*W-1:0] p2_p;
    logic [SW2-1:0] p2_sb;

    msc_mul #(.MW(W), .SW(SW2)) u_mul_var (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_a     ({1'b0, r1_vn}),
        .i_b     ({1'b0, r1_vm}),
        .i_sb    ({r1_cr, r1_cneg, r1_cmag, r1_bad, r1_flag}),
        .o_valid (p2_v),
        .o_p     (p2_p),
        .o_sb    (p2_sb)
    );

    logic           s_v;
    logic [W-2:0]   s_root;
    logic [SW2-1:0] s_sb;

    msc_sqrt #(.RW(W - 1), .SW(SW2)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p2_v),
        .i_p     (p2_p[2*W-3:0]),
        .i_sb    (p2_sb),
        .o_valid (s_v),
        .o_r     (s_root),
        .o_sb    (s_sb)
    );

    logic           d3_v;
    logic [W-1:0]   d3_q;
    logic           d3_ov;
    logic [SW2-1:0] d3_sb;

    msc_div #(.NW(W + F + 1), .DW(W - 1), .QW(W), .SW(SW2)) u_div_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_n     ((W + F + 1)'(s_sb[W+1:2]) << F),
        .i_d     (s_root),
        .i_sb    (s_sb),
        .o_valid (d3_v),
        .o_q     (d3_q),
        .o_ov    (d3_ov),
        .o_sb    (d3_sb)
    );

    // saturate the correlation coefficient
    logic         d3_cneg;
    logic [W-1:0] n2_limit;
    logic         n2_sat;
    logic [W-1:0] n2_m;

    assign d3_cneg  = d3_sb[W+2];
    assign n2_limit = d3_cneg ? HALF : HALF - W'(1);
    assign n2_sat   = d3_ov || (d3_q > n2_limit);
    assign n2_m     = n2_sat ? n2_limit : d3_q;

    logic         r2_v;
    logic [W-1:0] r2_cr;
    logic [W-1:0] r2_est;
    logic [W-1:0] r2_m;
    logic         r2_bad;
    logic         r2_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cr   <= d3_sb[SW2-1:W+3];
            r2_est  <= d3_cneg ? W'(-n2_m) : n2_m;
            r2_m    <= n2_m;
            r2_bad  <= d3_sb[1];
            // the ratio only exists in the correlation modes
            r2_flag <= d3_sb[0] || (ratio_mode && n2_sat);
        end
    end

    logic           p3_v;
    logic [2*W-1:0] p3_p;
    logic [SW3-1:0] p3_sb;

    msc_mul #(.MW(W), .SW(SW3)) u_mul_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_a     (r2_m),
        .i_b     (r2_m),
        .i_sb    ({r2_cr, r2_est, r2_bad, r2_flag}),
        .o_valid (p3_v),
        .o_p     (p3_p),
        .o_sb    (p3_sb)
    );

    // result selection
    logic [W-1:0]   f_cr;
    logic [W-1:0]   f_est;
    logic           f_bad;
    logic           f_flag;
    logic [2*W-1:0] n_pf;
    logic           n_dsat;
    logic [W-1:0]   n_det;
    logic [W-1:0]   n_out_est;
    t_status        n_out_st;

    assign f_cr   = p3_sb[SW3-1:W+2];
    assign f_est  = p3_sb[W+1:2];
    assign f_bad  = p3_sb[1];
    assign f_flag = p3_sb[0];
    assign n_pf   = p3_p >> F;
    assign n_dsat = n_pf > (2 * W)'(HALF - W'(1));
    assign n_det  = n_dsat ? HALF - W'(1) : n_pf[W-1:0];

    always_comb begin
        unique case (r_mode)
            MODE_SCATTER, MODE_COV: begin
                n_out_est = f_cr;
                n_out_st  = f_flag ? ST_SAT : ST_OK;
            end
            MODE_CORR: begin
                n_out_est = f_bad ? '0 : f_est;
                n_out_st  = f_bad ? ST_NONPOS : (f_flag ? ST_SAT : ST_OK);
            end
            MODE_DET: begin
                n_out_est = f_bad ? '0 : n_det;
                n_out_st  = f_bad ? ST_NONPOS : ((f_flag || n_dsat) ? ST_SAT : ST_OK);
            end
        endcase
    end

    logic [W-1:0] r_out_est;
    t_status      r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_est <= n_out_est;
            r_out_st  <= n_out_st;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_estimate = r_out_est;
    assign o_status   = r_out_st;

`ifndef SYNTHESIS
    a_nonpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NONPOS)) |-> (o_estimate == '0))
        else $error("non-positive variance result carries a nonzero estimate");

    a_det_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mode == MODE_DET)) |-> !o_estimate[W-1])
        else $error("determination coefficient is negative");

    a_nonpos_ratio_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((r_mode == MODE_SCATTER) || (r_mode == MODE_COV)))
            |-> (o_status != ST_NONPOS))
        else $error("variance check reported outside correlation modes");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r1_v) && $stable(r2_v)))
        else $error("pipeline advanced while output was stalled");
`endif

endmodule

`default_nettype wire
